// File: hw/rtl/i2csbc_pkg.sv
// Shared types and constants for the I2C slave byte controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package i2csbc_pkg;

    // FIFO geometry
    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int ADDR_W = 7;
    localparam int BYTE_W = 8;

    // Event codes carried on s_tuser
    typedef enum logic [2:0] {
        ACT_START    = 3'd0,
        ACT_OVERFLOW = 3'd1,
        ACT_STOP     = 3'd2,
        ACT_PUSH     = 3'd3,
        ACT_POP      = 3'd4
    } action_t;

    // Next shifter action
    typedef enum logic [2:0] {
        SH_IDLE   = 3'd0,
        SH_RECV   = 3'd1,
        SH_ACK    = 3'd2,
        SH_SEND   = 3'd3,
        SH_SAMPLE = 3'd4
    } shift_t;

    // Bus protocol phase
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ADRS     = 3'd1,
        PH_ADRS_ACK = 3'd2,
        PH_DATA_ACK = 3'd3,
        PH_DATA_IN  = 3'd4,
        PH_DATA_OUT = 3'd5,
        PH_CHK_ACK  = 3'd6
    } phase_t;

    // Controller to datapath
    typedef struct packed {
        logic   capture;     // latch the accepted input transfer
        logic   tx_push;
        logic   tx_pop;
        logic   rx_push;
        logic   rx_pop;
        logic   fifo_clear;
        logic   load_out;    // fill the output register
        shift_t next_shift;
        logic   stretch;
        phase_t phase;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] action;
        logic       addr_match;
        logic       line_lsb;
        logic       out_free;
    } sts_t;

endpackage

// File: hw/rtl/i2csbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package dependency.
module i2csbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/i2csbc_datapath.sv
// Datapath: input holding registers, address register, both ring FIFOs and
// the output register. Depends on i2csbc_pkg and i2csbc_ram.
module i2csbc_datapath
    import i2csbc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [2:0]        in_action,
    input  logic [BYTE_W-1:0] in_line_byte,
    input  logic [BYTE_W-1:0] in_host_data,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_data
);

    logic [2:0]        action_reg;
    logic [BYTE_W-1:0] line_reg;
    logic [BYTE_W-1:0] host_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic [PTR_W-1:0] tx_wr_reg, tx_wr_next, tx_rd_reg, tx_rd_next;
    logic [PTR_W-1:0] rx_wr_reg, rx_wr_next, rx_rd_reg, rx_rd_next;
    logic [CNT_W-1:0] tx_cnt_reg, tx_cnt_next, rx_cnt_reg, rx_cnt_next;
    logic             err_reg, err_next;
    logic             tx_hit_reg, tx_hit_next, rx_hit_reg, rx_hit_next;

    logic             tx_full, tx_empty, rx_full, rx_empty;
    logic             tx_we, tx_re, rx_we, rx_re;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;

    logic             out_valid_reg;
    logic [31:0]      out_data_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign tx_full  = (tx_cnt_reg == CNT_W'(FIFO_DEPTH));
    assign tx_empty = (tx_cnt_reg == '0);
    assign rx_full  = (rx_cnt_reg == CNT_W'(FIFO_DEPTH));
    assign rx_empty = (rx_cnt_reg == '0);

    assign tx_we = cmd.tx_push && !tx_full;
    assign tx_re = cmd.tx_pop && !tx_empty;
    assign rx_we = cmd.rx_push && !rx_full;
    assign rx_re = cmd.rx_pop && !rx_empty;

    // Pointer, count and error bookkeeping for one committed event
    always_comb begin
        tx_wr_next  = tx_wr_reg;
        tx_rd_next  = tx_rd_reg;
        tx_cnt_next = tx_cnt_reg;
        rx_wr_next  = rx_wr_reg;
        rx_rd_next  = rx_rd_reg;
        rx_cnt_next = rx_cnt_reg;
        err_next    = err_reg;
        tx_hit_next = tx_hit_reg;
        rx_hit_next = rx_hit_reg;
        if (cmd.fifo_clear) begin
            tx_wr_next  = '0;
            tx_rd_next  = '0;
            tx_cnt_next = '0;
            rx_wr_next  = '0;
            rx_rd_next  = '0;
            rx_cnt_next = '0;
        end
        if (tx_we) begin
            tx_wr_next  = ptr_inc(tx_wr_reg);
            tx_cnt_next = tx_cnt_reg + CNT_W'(1);
        end
        if (tx_re) begin
            tx_rd_next  = ptr_inc(tx_rd_reg);
            tx_cnt_next = tx_cnt_reg - CNT_W'(1);
        end
        if (rx_we) begin
            rx_wr_next  = ptr_inc(rx_wr_reg);
            rx_cnt_next = rx_cnt_reg + CNT_W'(1);
        end
        if (rx_re) begin
            rx_rd_next  = ptr_inc(rx_rd_reg);
            rx_cnt_next = rx_cnt_reg - CNT_W'(1);
        end
        if (cmd.capture) begin
            err_next    = 1'b0;
            tx_hit_next = 1'b0;
            rx_hit_next = 1'b0;
        end
        if (cmd.tx_push || cmd.tx_pop || cmd.rx_push || cmd.rx_pop) begin
            err_next = (cmd.tx_push && tx_full) || (cmd.tx_pop && tx_empty) ||
                       (cmd.rx_push && rx_full) || (cmd.rx_pop && rx_empty);
            tx_hit_next = tx_re;
            rx_hit_next = rx_re;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg      <= '0;
            tx_wr_reg     <= '0;
            tx_rd_reg     <= '0;
            tx_cnt_reg    <= '0;
            rx_wr_reg     <= '0;
            rx_rd_reg     <= '0;
            rx_cnt_reg    <= '0;
            err_reg       <= 1'b0;
            tx_hit_reg    <= 1'b0;
            rx_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                addr_reg <= cfg_addr;
            end
            tx_wr_reg  <= tx_wr_next;
            tx_rd_reg  <= tx_rd_next;
            tx_cnt_reg <= tx_cnt_next;
            rx_wr_reg  <= rx_wr_next;
            rx_rd_reg  <= rx_rd_next;
            rx_cnt_reg <= rx_cnt_next;
            err_reg    <= err_next;
            tx_hit_reg <= tx_hit_next;
            rx_hit_reg <= rx_hit_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= in_action;
            line_reg   <= in_line_byte;
            host_reg   <= in_host_data;
        end
        if (cmd.load_out) begin
            out_data_reg <= {6'd0,
                             cmd.phase,
                             err_reg,
                             (tx_cnt_reg == '0),
                             (rx_cnt_reg == '0),
                             (rx_hit_reg ? rx_rdata : BYTE_W'(0)),
                             cmd.stretch,
                             (tx_hit_reg ? tx_rdata : BYTE_W'(0)),
                             cmd.next_shift};
        end
    end

    i2csbc_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_wr_reg),
        .wdata (host_reg),
        .re    (tx_re),
        .raddr (tx_rd_reg),
        .rdata (tx_rdata)
    );

    i2csbc_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_wr_reg),
        .wdata (line_reg),
        .re    (rx_re),
        .raddr (rx_rd_reg),
        .rdata (rx_rdata)
    );

    assign sts.action     = action_reg;
    assign sts.addr_match = (line_reg[BYTE_W-1:1] == addr_reg);
    assign sts.line_lsb   = line_reg[0];
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hw/rtl/i2csbc_ctrl.sv
// Controller: event sequencer plus the I2C protocol state (phase, read/write
// direction, stretch enable). Depends on i2csbc_pkg.
module i2csbc_ctrl
    import i2csbc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    shift_t shift_reg, shift_next;
    logic   reads_reg, reads_next;
    logic   stretch_reg, stretch_next;
    logic   tx_push, tx_pop, rx_push, rx_pop, fifo_clear;

    // Decode one event against the protocol phase
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        reads_next   = reads_reg;
        stretch_next = stretch_reg;
        tx_push      = 1'b0;
        tx_pop       = 1'b0;
        rx_push      = 1'b0;
        rx_pop       = 1'b0;
        fifo_clear   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_LOAD;
                shift_next = SH_IDLE;
                case (sts.action)
                    ACT_START: begin
                        phase_next   = PH_ADRS;
                        stretch_next = 1'b1;
                        shift_next   = SH_RECV;
                    end
                    ACT_OVERFLOW: begin
                        case (phase_reg)
                            PH_ADRS: begin
                                if (sts.addr_match) begin
                                    reads_next = sts.line_lsb;
                                    shift_next = SH_ACK;
                                    phase_next = PH_ADRS_ACK;
                                end else begin
                                    phase_next = PH_IDLE;
                                end
                            end
                            PH_ADRS_ACK: begin
                                if (reads_reg) begin
                                    tx_pop     = 1'b1;
                                    shift_next = SH_SEND;
                                    phase_next = PH_DATA_OUT;
                                end else begin
                                    shift_next = SH_RECV;
                                    phase_next = PH_DATA_IN;
                                end
                            end
                            PH_DATA_ACK: begin
                                shift_next = SH_RECV;
                                phase_next = PH_DATA_IN;
                            end
                            PH_DATA_IN: begin
                                rx_push    = 1'b1;
                                shift_next = SH_ACK;
                                phase_next = PH_DATA_ACK;
                            end
                            PH_DATA_OUT: begin
                                shift_next = SH_SAMPLE;
                                phase_next = PH_CHK_ACK;
                            end
                            PH_CHK_ACK: begin
                                if (!sts.line_lsb) begin
                                    tx_pop     = 1'b1;
                                    shift_next = SH_SEND;
                                    phase_next = PH_DATA_OUT;
                                end else begin
                                    phase_next   = PH_IDLE;
                                    stretch_next = 1'b0;
                                end
                            end
                            default: begin
                                // overflow with no transfer open: reinitialize
                                phase_next   = PH_IDLE;
                                reads_next   = 1'b1;
                                stretch_next = 1'b0;
                                fifo_clear   = 1'b1;
                            end
                        endcase
                    end
                    ACT_STOP: begin
                        phase_next   = PH_IDLE;
                        stretch_next = 1'b0;
                    end
                    ACT_PUSH: begin
                        tx_push = 1'b1;
                    end
                    ACT_POP: begin
                        rx_pop = 1'b1;
                    end
                    default: begin
                        // unused codes leave the protocol state alone; only the next shift goes idle
                    end
                endcase
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and protocol registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_IDLE;
            shift_reg   <= SH_IDLE;
            reads_reg   <= 1'b1;
            stretch_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            reads_reg   <= reads_next;
            stretch_reg <= stretch_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    assign cmd.capture    = (state_reg == ST_IDLE) && in_valid;
    assign cmd.tx_push    = tx_push;
    assign cmd.tx_pop     = tx_pop;
    assign cmd.rx_push    = rx_push;
    assign cmd.rx_pop     = rx_pop;
    assign cmd.fifo_clear = fifo_clear;
    assign cmd.load_out   = (state_reg == ST_LOAD) && sts.out_free;
    assign cmd.next_shift = shift_reg;
    assign cmd.stretch    = stretch_reg;
    assign cmd.phase      = phase_reg;

endmodule

// File: hw/rtl/i2c_slave_byte_controller.sv
// I2C slave byte controller, 7-bit address, with transmit and receive FIFOs.
// Top level: joins i2csbc_ctrl and i2csbc_datapath; depends on i2csbc_pkg.
//
// Each event (start, shift overflow, stop, host push, host pop) arrives as one
// stream transfer and produces exactly one result transfer. An event is
// captured in the accepting cycle, then decoded with its FIFO update, then
// loaded into the output register in a load step that also collects the
// registered read of the FIFO memory. The next event is accepted only after
// that load, so the block takes no new event while one is still in flight.
// A new event is taken while the previous result still waits in the output
// register; the load stalls only if that result has not been taken by then.
// The address register is written over the cfg channel, which is always
// ready.
module i2c_slave_byte_controller
    import i2csbc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,      // slave_address
    // event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // line_byte [7:0], host_data [15:8]
    input  logic [2:0]  s_tuser,       // action
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // next_shift [2:0], shift_byte [10:3],
                                       // stretch_on [11], host_byte [19:12],
                                       // rx_empty [20], tx_empty [21],
                                       // fifo_error [22], phase [25:23], zero
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    i2csbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    i2csbc_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_action    (s_tuser),
        .in_line_byte (s_tdata[7:0]),
        .in_host_data (s_tdata[15:8]),
        .cfg_we       (cfg_valid),
        .cfg_addr     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (m_tdata)
    );

endmodule

// File: test/testbench.sv
// Self-checking bench for i2c_slave_byte_controller: event stream in, one result per event.
// Predicts each result from its own copy of the bus phase and both FIFOs, or takes it from the directed table.
// Depends on i2csbc_pkg and the RTL under hw/rtl only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import i2csbc_pkg::*;

    localparam int          CLK_HALF      = 10;
    localparam int          RESET_CYCLES  = 5;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_EVENTS  = 300;
    localparam realtime     RUN_LIMIT     = 40ms;

    // codes the package leaves out: the block ignores them
    localparam logic [2:0]  ACT_RESERVED_FIRST = 3'd5;
    localparam logic [2:0]  ACT_RESERVED_LAST  = 3'd7;

    // bit 0 of a shifted byte: R/W bit of an address byte, ack sample otherwise
    localparam logic        RW_WRITE = 1'b0;
    localparam logic        RW_READ  = 1'b1;
    localparam logic        ACK      = 1'b0;
    localparam logic        NAK      = 1'b1;

    typedef logic [BYTE_W-1:0] octet_t;

    typedef struct packed {
        shift_t     next_shift;
        octet_t     shift_byte;
        logic       stretch_on;
        octet_t     host_byte;
        logic       rx_empty;
        logic       tx_empty;
        logic       fifo_error;
        phase_t     phase;
    } bus_result_t;

    typedef struct packed {
        logic [2:0]  action;
        octet_t      line_byte;
        octet_t      host_data;
        logic        fixed_exp;
        bus_result_t want;
    } stim_row_t;

    localparam bus_result_t NO_RESULT = '0;

    // Directed events, slave address still at its reset value of zero.
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        // pop from the empty receive FIFO straight after reset
        '{ACT_POP, 8'h00, 8'h00, 1'b1,
          '{SH_IDLE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1, PH_IDLE}},
        // overflow while idle reinitializes
        '{ACT_OVERFLOW, 8'hFF, 8'h00, 1'b1,
          '{SH_IDLE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, PH_IDLE}},
        '{ACT_PUSH, 8'h00, 8'hFF, 1'b1,
          '{SH_IDLE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, PH_IDLE}},
        '{ACT_PUSH, 8'hFF, 8'h00, 1'b0, NO_RESULT},
        '{ACT_START, 8'h00, 8'h00, 1'b1,
          '{SH_RECV, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, PH_ADRS}},
        // read from address zero
        '{ACT_OVERFLOW, 8'h01, 8'h00, 1'b0, NO_RESULT},
        '{ACT_OVERFLOW, 8'h00, 8'h00, 1'b1,
          '{SH_SEND, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, PH_DATA_OUT}},
        '{ACT_OVERFLOW, 8'hFF, 8'h00, 1'b0, NO_RESULT},
        '{ACT_OVERFLOW, 8'hFE, 8'h00, 1'b0, NO_RESULT},
        '{ACT_OVERFLOW, 8'h00, 8'h00, 1'b0, NO_RESULT},
        // master acks but the transmit FIFO ran dry: zero goes out, error flagged
        '{ACT_OVERFLOW, 8'h00, 8'h00, 1'b1,
          '{SH_SEND, 8'h00, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1, PH_DATA_OUT}},
        '{ACT_OVERFLOW, 8'h00, 8'h00, 1'b0, NO_RESULT},
        // master NAK ends the read
        '{ACT_OVERFLOW, 8'h01, 8'h00, 1'b0, NO_RESULT},
        // address mismatch leaves stretching on
        '{ACT_START, 8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ACT_OVERFLOW, 8'hFE, 8'hFF, 1'b0, NO_RESULT},
        // write of two bytes, then stop
        '{ACT_START, 8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ACT_OVERFLOW, 8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ACT_OVERFLOW, 8'h5A, 8'h00, 1'b0, NO_RESULT},
        '{ACT_OVERFLOW, 8'hA5, 8'h00, 1'b0, NO_RESULT},
        '{ACT_OVERFLOW, 8'hFF, 8'h00, 1'b0, NO_RESULT},
        '{ACT_OVERFLOW, 8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ACT_STOP, 8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ACT_POP, 8'h00, 8'h00, 1'b0, NO_RESULT},
        '{ACT_POP, 8'hFF, 8'hFF, 1'b0, NO_RESULT},
        // reserved code: nothing changes
        '{ACT_RESERVED_LAST, 8'hFF, 8'hFF, 1'b0, NO_RESULT}
    };

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [ADDR_W-1:0]  cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata   = '0;     // line_byte [7:0], host_data [15:8]
    logic [2:0]         s_tuser   = '0;     // action
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [31:0]        m_tdata;            // next_shift, shift_byte, stretch_on, host_byte,
                                            // rx_empty, tx_empty, fifo_error, phase

    // predictor state
    logic [ADDR_W-1:0]  own_address  = '0;
    phase_t             bus_phase    = PH_IDLE;
    logic               master_reads = 1'b1;
    logic               stretch_en   = 1'b0;
    octet_t             tx_bytes[$];
    octet_t             rx_bytes[$];

    bus_result_t        pending_results[$];
    int                 events_sent    = 0;
    int                 mismatch_count = 0;
    bit                 send_calm      = 1'b0;
    bit                 recv_calm      = 1'b0;
    int                 stall_left     = 0;

    i2c_slave_byte_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Advance the bus model by one event and return the result it owes.
    function automatic bus_result_t predict_bus_event(input logic [2:0] act,
                                                      input octet_t line,
                                                      input octet_t hdata);
        bus_result_t r;
        r = '0;
        case (act)
            ACT_START: begin
                bus_phase    = PH_ADRS;
                stretch_en   = 1'b1;
                r.next_shift = SH_RECV;
            end
            ACT_OVERFLOW: begin
                case (bus_phase)
                    PH_ADRS: begin
                        if (line[7:1] == own_address) begin
                            master_reads = line[0];
                            r.next_shift = SH_ACK;
                            bus_phase    = PH_ADRS_ACK;
                        end else begin
                            bus_phase = PH_IDLE;
                        end
                    end
                    PH_ADRS_ACK: begin
                        if (master_reads) begin
                            if (tx_bytes.size() == 0) r.fifo_error = 1'b1;
                            else r.shift_byte = tx_bytes.pop_front();
                            r.next_shift = SH_SEND;
                            bus_phase    = PH_DATA_OUT;
                        end else begin
                            r.next_shift = SH_RECV;
                            bus_phase    = PH_DATA_IN;
                        end
                    end
                    PH_DATA_ACK: begin
                        r.next_shift = SH_RECV;
                        bus_phase    = PH_DATA_IN;
                    end
                    PH_DATA_IN: begin
                        // still acked when the receive FIFO is full
                        if (rx_bytes.size() < FIFO_DEPTH) rx_bytes.push_back(line);
                        else r.fifo_error = 1'b1;
                        r.next_shift = SH_ACK;
                        bus_phase    = PH_DATA_ACK;
                    end
                    PH_DATA_OUT: begin
                        r.next_shift = SH_SAMPLE;
                        bus_phase    = PH_CHK_ACK;
                    end
                    PH_CHK_ACK: begin
                        if (line[0] == ACK) begin
                            if (tx_bytes.size() == 0) r.fifo_error = 1'b1;
                            else r.shift_byte = tx_bytes.pop_front();
                            r.next_shift = SH_SEND;
                            bus_phase    = PH_DATA_OUT;
                        end else begin
                            bus_phase  = PH_IDLE;
                            stretch_en = 1'b0;
                        end
                    end
                    default: begin
                        // overflow while idle: start over, keep the address
                        bus_phase    = PH_IDLE;
                        master_reads = 1'b1;
                        stretch_en   = 1'b0;
                        tx_bytes.delete();
                        rx_bytes.delete();
                    end
                endcase
            end
            ACT_STOP: begin
                bus_phase  = PH_IDLE;
                stretch_en = 1'b0;
            end
            ACT_PUSH: begin
                if (tx_bytes.size() < FIFO_DEPTH) tx_bytes.push_back(hdata);
                else r.fifo_error = 1'b1;
            end
            ACT_POP: begin
                if (rx_bytes.size() == 0) r.fifo_error = 1'b1;
                else r.host_byte = rx_bytes.pop_front();
            end
            default: ;
        endcase
        r.stretch_on = stretch_en;
        r.rx_empty   = (rx_bytes.size() == 0);
        r.tx_empty   = (tx_bytes.size() == 0);
        r.phase      = bus_phase;
        return r;
    endfunction

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic octet_t rand_octet();
        return octet_t'($urandom);
    endfunction

    // Mostly our own address, sometimes any other.
    function automatic logic [ADDR_W-1:0] pick_address();
        if ($urandom_range(9) == 0) return ADDR_W'($urandom);
        return own_address;
    endfunction

    // Short runs, with the odd one long enough to overrun a FIFO.
    function automatic int pick_run_length();
        if ($urandom_range(9) == 0) return $urandom_range(FIFO_DEPTH - 4, FIFO_DEPTH + 16);
        return $urandom_range(0, 6);
    endfunction

    // Drive one event and record what it must produce once the transfer is taken.
    task automatic send_event(input logic [2:0] act, input octet_t line, input octet_t hdata,
                              input bit fixed_exp = 1'b0, input bus_result_t want = '0);
        int          gap;
        bus_result_t predicted;
        @(negedge aclk);
        if ($urandom_range(49) == 0) send_calm = !send_calm;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {hdata, line};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_bus_event(act, line, hdata);
        pending_results.push_back(fixed_exp ? want : predicted);
        if (act <= ACT_POP) events_sent++;
    endtask

    // Occasionally slip a host access in between bus events.
    task automatic maybe_host_event();
        if ($urandom_range(4) == 0) begin
            if ($urandom_range(1)) send_event(ACT_PUSH, rand_octet(), rand_octet());
            else send_event(ACT_POP, rand_octet(), rand_octet());
        end
    endtask

    // Drop valid, then wait until every result is back and the pipeline is empty.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_address(input logic [ADDR_W-1:0] addr);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        own_address = addr;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed bus transfers with random content, plus host bursts and noise.
    task automatic run_random_phase(input int quota);
        int first;
        int k;
        first = events_sent;
        while (events_sent - first < quota) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    // master writes k bytes
                    send_event(ACT_START, rand_octet(), rand_octet());
                    send_event(ACT_OVERFLOW, {pick_address(), RW_WRITE}, rand_octet());
                    send_event(ACT_OVERFLOW, rand_octet(), rand_octet());
                    k = pick_run_length();
                    repeat (k) begin
                        maybe_host_event();
                        send_event(ACT_OVERFLOW, rand_octet(), rand_octet());
                        send_event(ACT_OVERFLOW, rand_octet(), rand_octet());
                    end
                    if ($urandom_range(4) != 0) send_event(ACT_STOP, rand_octet(), rand_octet());
                end
                3, 4, 5: begin
                    // master reads k+1 bytes and NAKs the last
                    send_event(ACT_START, rand_octet(), rand_octet());
                    send_event(ACT_OVERFLOW, {pick_address(), RW_READ}, rand_octet());
                    send_event(ACT_OVERFLOW, rand_octet(), rand_octet());
                    k = pick_run_length();
                    repeat (k) begin
                        send_event(ACT_OVERFLOW, rand_octet(), rand_octet());
                        maybe_host_event();
                        send_event(ACT_OVERFLOW, {7'($urandom), ACK}, rand_octet());
                    end
                    send_event(ACT_OVERFLOW, rand_octet(), rand_octet());
                    send_event(ACT_OVERFLOW, {7'($urandom), NAK}, rand_octet());
                    if ($urandom_range(3) != 0) send_event(ACT_STOP, rand_octet(), rand_octet());
                end
                6, 7: begin
                    // host fills or drains a FIFO
                    k = pick_run_length() + 1;
                    if ($urandom_range(1)) begin
                        repeat (k) send_event(ACT_PUSH, rand_octet(), rand_octet());
                    end else begin
                        repeat (k) send_event(ACT_POP, rand_octet(), rand_octet());
                    end
                end
                default: begin
                    repeat (3) begin
                        if ($urandom_range(15) == 0)
                            send_event(3'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST)),
                                       rand_octet(), rand_octet());
                        else
                            send_event(3'($urandom_range(ACT_START, ACT_POP)),
                                       rand_octet(), rand_octet());
                    end
                end
            endcase
        end
    endtask

    task automatic check_result(input bus_result_t exp, input bus_result_t got);
        if (got.next_shift !== exp.next_shift) begin
            $error("next_shift: expected %0d, got %0d", exp.next_shift, got.next_shift);
            mismatch_count++;
        end
        if (got.shift_byte !== exp.shift_byte) begin
            $error("shift_byte: expected %0h, got %0h", exp.shift_byte, got.shift_byte);
            mismatch_count++;
        end
        if (got.stretch_on !== exp.stretch_on) begin
            $error("stretch_on: expected %0b, got %0b", exp.stretch_on, got.stretch_on);
            mismatch_count++;
        end
        if (got.host_byte !== exp.host_byte) begin
            $error("host_byte: expected %0h, got %0h", exp.host_byte, got.host_byte);
            mismatch_count++;
        end
        if (got.rx_empty !== exp.rx_empty) begin
            $error("rx_empty: expected %0b, got %0b", exp.rx_empty, got.rx_empty);
            mismatch_count++;
        end
        if (got.tx_empty !== exp.tx_empty) begin
            $error("tx_empty: expected %0b, got %0b", exp.tx_empty, got.tx_empty);
            mismatch_count++;
        end
        if (got.fifo_error !== exp.fifo_error) begin
            $error("fifo_error: expected %0b, got %0b", exp.fifo_error, got.fifo_error);
            mismatch_count++;
        end
        if (got.phase !== exp.phase) begin
            $error("phase: expected %0d, got %0d", exp.phase, got.phase);
            mismatch_count++;
        end
    endtask

    // Stall the result side at random, with calm stretches.
    always @(negedge aclk) begin
        if ($urandom_range(99) == 0) recv_calm = !recv_calm;
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap(recv_calm);
        end
    end

    // Unpack each result transfer and compare it with the oldest expectation.
    always @(posedge aclk) begin
        bus_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.next_shift = shift_t'(m_tdata[2:0]);
            got.shift_byte = m_tdata[10:3];
            got.stretch_on = m_tdata[11];
            got.host_byte  = m_tdata[19:12];
            got.rx_empty   = m_tdata[20];
            got.tx_empty   = m_tdata[21];
            got.fifo_error = m_tdata[22];
            got.phase      = phase_t'(m_tdata[25:23]);
            if (pending_results.size() == 0) begin
                $error("result transfer with no event outstanding: %0h", m_tdata);
                mismatch_count++;
            end else begin
                check_result(pending_results.pop_front(), got);
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_event(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].line_byte,
                       DIRECTED_ROWS[i].host_data, DIRECTED_ROWS[i].fixed_exp,
                       DIRECTED_ROWS[i].want);

        // change the address only with the block drained; extremes first
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            if (p == 0) write_address({ADDR_W{1'b1}});
            else if (p == 1) write_address('0);
            else write_address(ADDR_W'($urandom));
            run_random_phase(PHASE_EVENTS);
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop if the handshakes hang.
    initial begin
        #(RUN_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
